/* sv/fclp_pkg.sv */
package fclp_pkg;

  localparam int COMMAND_WORDS = 7;
  localparam int REPLY_BYTES   = 16;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);

  localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
  localparam logic [7:0]  START_BYTE  = 8'h7F;
  localparam logic [15:0] SCALE_RESET = 16'd10000;
  localparam logic [2:0]  LAST_WORD   = 3'(COMMAND_WORDS - 1);

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_WORD  = 2'd1,
    KIND_ERR   = 2'd2
  } kind_t;

  // one queued operation: a line error, a command word or a telemetry reply
  typedef struct packed {
    kind_t             kind;
    logic [2:0]        word_index;
    logic [15:0]       word_value;
    logic              frame_done;
    logic [3:0][31:0]  tele;
  } fclp_op_t;

  typedef enum logic {
    BK_IDLE,
    BK_REPLY
  } back_state_t;

endpackage

/* sv/fclp_queue.sv */
module fclp_queue
  import fclp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  fclp_op_t   push_op,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output fclp_op_t   head_op
);

  fclp_op_t                entry_r [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r;
  logic [QPTR_W-1:0]       rd_ptr_r;
  logic [QPTR_W:0]         count_r;
  logic                    do_push;
  logic                    do_pop;

  assign full       = (count_r == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

/* sv/fclp_front.sv */
module fclp_front
  import fclp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_rx_error,
  input  logic signed [31:0] in_telemetry_a,
  input  logic signed [31:0] in_telemetry_b,
  input  logic signed [31:0] in_telemetry_c,
  input  logic signed [31:0] in_telemetry_d,
  input  logic               q_full,
  output logic               q_push,
  output fclp_op_t           q_op
);

  logic       in_frame_r, in_frame_nxt;
  logic       need_sync_r, need_sync_nxt;
  logic [3:0] byte_pos_r, byte_pos_nxt;
  logic [7:0] low_hold_r, low_hold_nxt;
  logic       accept;
  logic [2:0] widx;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign widx     = byte_pos_r[3:1];

  always_comb begin
    in_frame_nxt  = in_frame_r;
    need_sync_nxt = need_sync_r;
    byte_pos_nxt  = byte_pos_r;
    low_hold_nxt  = low_hold_r;
    q_push        = 1'b0;
    q_op.kind       = KIND_ERR;
    q_op.word_index = '0;
    q_op.word_value = '0;
    q_op.frame_done = 1'b0;
    q_op.tele       = {in_telemetry_d, in_telemetry_c, in_telemetry_b, in_telemetry_a};
    if (accept) begin
      if (in_rx_error) begin
        q_push = 1'b1;
      end else if (!in_frame_r) begin
        if (need_sync_r) begin
          if (in_rx_byte == SYNC_BYTE) begin
            need_sync_nxt = 1'b0;
          end
        end else begin
          need_sync_nxt = 1'b1;
          if (in_rx_byte == START_BYTE) begin
            in_frame_nxt = 1'b1;
            byte_pos_nxt = '0;
            q_push       = 1'b1;
            q_op.kind    = KIND_REPLY;
          end
        end
      end else if (!byte_pos_r[0]) begin
        low_hold_nxt = in_rx_byte;
        byte_pos_nxt = byte_pos_r + 1'b1;
      end else begin
        q_push          = 1'b1;
        q_op.kind       = KIND_WORD;
        q_op.word_index = widx;
        q_op.word_value = {in_rx_byte, low_hold_r};
        q_op.frame_done = (widx >= LAST_WORD);
        if (widx >= LAST_WORD) begin
          in_frame_nxt = 1'b0;
          byte_pos_nxt = '0;
        end else begin
          byte_pos_nxt = byte_pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      need_sync_r <= 1'b0;
      byte_pos_r  <= '0;
      low_hold_r  <= '0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      need_sync_r <= need_sync_nxt;
      byte_pos_r  <= byte_pos_nxt;
      low_hold_r  <= low_hold_nxt;
    end
  end

endmodule

/* sv/fclp_back.sv */
module fclp_back
  import fclp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        scale,
  input  logic               q_valid,
  input  fclp_op_t           q_op,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_tx_byte,
  output logic [2:0]         out_word_index,
  output logic signed [15:0] out_word_value,
  output logic               out_frame_done,
  output logic               out_last
);

  localparam int         SEQ_W    = $clog2(REPLY_BYTES + 3);
  localparam logic [SEQ_W-1:0] EMIT_LAT = SEQ_W'(2);
  localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(2 + REPLY_BYTES - 1);
  localparam logic [SEQ_W-1:0] MUL_LAST = SEQ_W'(3);
  localparam logic [SEQ_W-1:0] SAT_LAST = SEQ_W'(4);

  back_state_t          state_r, state_nxt;
  logic [SEQ_W-1:0]     seq_r, seq_nxt;
  logic [3:0][31:0]     tele_r;
  logic [3:0][31:0]     scaled_r;
  logic [47:0]          prod_r;
  logic                 neg_r;

  logic                 out_valid_r, out_valid_nxt;
  kind_t                out_kind_r, out_kind_nxt;
  logic [7:0]           out_tx_byte_r, out_tx_byte_nxt;
  logic [2:0]           out_word_index_r, out_word_index_nxt;
  logic [15:0]          out_word_value_r, out_word_value_nxt;
  logic                 out_frame_done_r, out_frame_done_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 out_room;
  logic                 advance;
  logic                 tele_ld;
  logic                 load;
  logic [31:0]          mul_src;
  logic                 mul_neg;
  logic [31:0]          mul_mag;
  logic [31:0]          quot;
  logic [31:0]          quot_neg;
  logic [31:0]          sat_val;
  logic [3:0]           bidx;

  assign out_room = !out_valid_r || out_ready;
  assign bidx     = 4'(seq_r - EMIT_LAT);

  // magnitude times scale
  assign mul_src = tele_r[seq_r[1:0]];
  assign mul_neg = mul_src[31];
  assign mul_mag = mul_neg ? (32'd0 - mul_src) : mul_src;

  // drop 16 fraction bits, saturate to signed 32
  assign quot     = prod_r[47:16];
  assign quot_neg = (quot > 32'h8000_0000) ? 32'h8000_0000 : quot;
  assign sat_val  = neg_r ? (32'd0 - quot_neg) : (quot[31] ? 32'h7FFF_FFFF : quot);

  always_comb begin
    state_nxt          = state_r;
    seq_nxt            = seq_r;
    q_pop              = 1'b0;
    tele_ld            = 1'b0;
    advance            = 1'b0;
    load               = 1'b0;
    out_kind_nxt       = out_kind_r;
    out_tx_byte_nxt    = out_tx_byte_r;
    out_word_index_nxt = out_word_index_r;
    out_word_value_nxt = out_word_value_r;
    out_frame_done_nxt = out_frame_done_r;
    out_last_nxt       = out_last_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_op.kind == KIND_REPLY) begin
            q_pop     = 1'b1;
            tele_ld   = 1'b1;
            seq_nxt   = '0;
            state_nxt = BK_REPLY;
          end else if (out_room) begin
            q_pop              = 1'b1;
            load               = 1'b1;
            out_kind_nxt       = q_op.kind;
            out_tx_byte_nxt    = '0;
            out_word_index_nxt = q_op.word_index;
            out_word_value_nxt = q_op.word_value;
            out_frame_done_nxt = q_op.frame_done;
            out_last_nxt       = 1'b1;
          end
        end
      end
      BK_REPLY: begin
        advance = (seq_r < EMIT_LAT) || out_room;
        if (advance) begin
          seq_nxt = seq_r + 1'b1;
          if (seq_r >= EMIT_LAT) begin
            load               = 1'b1;
            out_kind_nxt       = KIND_REPLY;
            out_tx_byte_nxt    = 8'(scaled_r[bidx[3:2]] >> {bidx[1:0], 3'b000});
            out_word_index_nxt = '0;
            out_word_value_nxt = '0;
            out_frame_done_nxt = 1'b0;
            out_last_nxt       = (seq_r == SEQ_LAST);
          end
          if (seq_r == SEQ_LAST) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
    out_valid_nxt = load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tele_ld) begin
      tele_r <= q_op.tele;
    end
    if (advance && seq_r <= MUL_LAST) begin
      prod_r <= 48'(mul_mag) * 48'(scale);
      neg_r  <= mul_neg;
    end
    if (advance && seq_r >= SEQ_W'(1) && seq_r <= SAT_LAST) begin
      scaled_r[2'(seq_r - SEQ_W'(1))] <= sat_val;
    end
    out_kind_r       <= out_kind_nxt;
    out_tx_byte_r    <= out_tx_byte_nxt;
    out_word_index_r <= out_word_index_nxt;
    out_word_value_r <= out_word_value_nxt;
    out_frame_done_r <= out_frame_done_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_tx_byte    = out_tx_byte_r;
  assign out_word_index = out_word_index_r;
  assign out_word_value = out_word_value_r;
  assign out_frame_done = out_frame_done_r;
  assign out_last       = out_last_r;

endmodule

/* sv/framed_command_link_parser_core.sv */
// Framed command link parser. Each word is one received serial byte with its
// error flag plus four Q16.16 telemetry values sampled with it. The front end
// runs the sync/frame state and takes one word per cycle while its 4-entry op
// queue has room; bytes that produce nothing never enter the queue. Line
// errors and command words leave as one result each, one per cycle while
// out_ready is high. A start byte leaves 16 reply bytes (telemetry a..d, LSB
// first, each scaled by cfg_data and saturated): the back end pops the op,
// runs each value through the 32x16 multiplier and the saturation register,
// then sends one byte per cycle while out_ready is high. Output is registered;
// input is taken during replies until the queue fills. Scale resets to 10000;
// the user is to write it with cfg_we while the block is idle (unchecked).
module framed_command_link_parser_core
  import fclp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_rx_error,
  input  logic signed [31:0] in_telemetry_a,
  input  logic signed [31:0] in_telemetry_b,
  input  logic signed [31:0] in_telemetry_c,
  input  logic signed [31:0] in_telemetry_d,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_tx_byte,
  output logic [2:0]         out_word_index,
  output logic signed [15:0] out_word_value,
  output logic               out_frame_done,
  output logic               out_last
);

  logic [15:0] scale_r;
  logic        q_full;
  logic        q_push;
  fclp_op_t    push_op;
  fclp_op_t    head_op;
  logic        q_head_valid;
  logic        q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_data;
    end
  end

  fclp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .in_rx_error    (in_rx_error),
    .in_telemetry_a (in_telemetry_a),
    .in_telemetry_b (in_telemetry_b),
    .in_telemetry_c (in_telemetry_c),
    .in_telemetry_d (in_telemetry_d),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_op           (push_op)
  );

  fclp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_op    (head_op)
  );

  fclp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .scale          (scale_r),
    .q_valid        (q_head_valid),
    .q_op           (head_op),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_tx_byte    (out_tx_byte),
    .out_word_index (out_word_index),
    .out_word_value (out_word_value),
    .out_frame_done (out_frame_done),
    .out_last       (out_last)
  );

endmodule

/* sv/fclp_checker.sv */
module fclp_checker
  import fclp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_kind,
  input logic [7:0]         out_tx_byte,
  input logic [2:0]         out_word_index,
  input logic signed [15:0] out_word_value,
  input logic               out_frame_done,
  input logic               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_tx_byte)
      && $stable(out_word_value) && $stable(out_last))
    else $error("result word changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_REPLY |-> out_last)
    else $error("error or command word without last");

  a_word_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_WORD |-> out_word_value == 16'sd0
      && out_word_index == 3'd0 && !out_frame_done)
    else $error("command word fields set on non-word result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind framed_command_link_parser_core fclp_checker u_fclp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_kind       (out_kind),
  .out_tx_byte    (out_tx_byte),
  .out_word_index (out_word_index),
  .out_word_value (out_word_value),
  .out_frame_done (out_frame_done),
  .out_last       (out_last)
);

/* dv/tb_framed_command_link_parser_core.sv */
`timescale 1ns / 1ps

module tb_framed_command_link_parser_core;
  import fclp_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic [2:0]  word_index;
    logic [15:0] word_value;
    logic        frame_done;
    logic        last;
  } link_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_rx_byte;
  logic               in_rx_error;
  logic signed [31:0] in_telemetry_a;
  logic signed [31:0] in_telemetry_b;
  logic signed [31:0] in_telemetry_c;
  logic signed [31:0] in_telemetry_d;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_kind;
  logic [7:0]         out_tx_byte;
  logic [2:0]         out_word_index;
  logic signed [15:0] out_word_value;
  logic               out_frame_done;
  logic               out_last;

  // mirror of the parser state
  logic [15:0] scale_q    = SCALE_RESET;
  logic        in_frame_q = 1'b0;
  logic        need_sync_q = 1'b0;
  logic [3:0]  pos_q      = 4'd0;
  logic [7:0]  low_q      = 8'd0;

  link_result_t expected_results[$];

  bit quiet_phase = 1'b0;
  int hold_req    = 0;
  int mismatches  = 0;
  int words_sent  = 0;
  int active_words = 0;
  int n_replies   = 0;
  int n_cmds      = 0;
  int n_errs      = 0;
  int n_frames    = 0;
  int n_scales    = 0;

  framed_command_link_parser_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .in_rx_error    (in_rx_error),
    .in_telemetry_a (in_telemetry_a),
    .in_telemetry_b (in_telemetry_b),
    .in_telemetry_c (in_telemetry_c),
    .in_telemetry_d (in_telemetry_d),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_tx_byte    (out_tx_byte),
    .out_word_index (out_word_index),
    .out_word_value (out_word_value),
    .out_frame_done (out_frame_done),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  // Q16.16 times scale, truncated toward zero, saturated to 32 bits
  function automatic logic [31:0] scaled_telemetry(logic [31:0] t, logic [15:0] s);
    logic [63:0] mag;
    logic [63:0] q;
    mag = t[31] ? (64'h1_0000_0000 - {32'h0, t}) : {32'h0, t};
    q = (mag * {48'h0, s}) >> 16;
    if (t[31]) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'h0 - q[31:0];
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  task automatic push_result(kind_t k, logic [7:0] tx, logic [2:0] idx, logic [15:0] val,
                             logic done, logic lst);
    link_result_t r;
    r.kind       = k;
    r.tx_byte    = tx;
    r.word_index = idx;
    r.word_value = val;
    r.frame_done = done;
    r.last       = lst;
    expected_results.push_back(r);
  endtask

  task automatic predict_parser_results(logic [7:0] b, logic e, logic [3:0][31:0] tele);
    logic [31:0] s;
    logic [2:0]  widx;
    logic        done;
    if (e) begin
      active_words++;
      push_result(KIND_ERR, 8'h00, 3'd0, 16'h0000, 1'b0, 1'b1);
      return;
    end
    if (!in_frame_q) begin
      if (need_sync_q) begin
        if (b == SYNC_BYTE) begin
          need_sync_q = 1'b0;
          active_words++;
        end
        return;
      end
      active_words++;
      need_sync_q = 1'b1;
      if (b != START_BYTE) return;
      in_frame_q = 1'b1;
      pos_q = 4'd0;
      n_frames++;
      for (int v = 0; v < 4; v++) begin
        s = scaled_telemetry(tele[v], scale_q);
        for (int i = 0; i < 4; i++)
          push_result(KIND_REPLY, s[8*i +: 8], 3'd0, 16'h0000, 1'b0, (v == 3 && i == 3));
      end
      return;
    end
    active_words++;
    if (!pos_q[0]) begin
      low_q = b;
      pos_q = pos_q + 4'd1;
      return;
    end
    widx = pos_q[3:1];
    done = (widx >= LAST_WORD);
    if (done) begin
      in_frame_q = 1'b0;
      pos_q = 4'd0;
    end else begin
      pos_q = pos_q + 4'd1;
    end
    push_result(KIND_WORD, 8'h00, widx, {b, low_q}, done, 1'b1);
  endtask

  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] rand_tele();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0][31:0] rand_tele_set();
    return {rand_tele(), rand_tele(), rand_tele(), rand_tele()};
  endfunction

  task automatic send_byte(logic [7:0] b, logic e, logic [3:0][31:0] tele);
    int gap;
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_rx_error    <= e;
    in_telemetry_a <= tele[0];
    in_telemetry_b <= tele[1];
    in_telemetry_c <= tele[2];
    in_telemetry_d <= tele[3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_parser_results(b, e, tele);
    words_sent++;
    gap = (quiet_phase || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && n < 50000) begin
      @(posedge clk);
      n++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches++;
      expected_results.delete();
    end
    repeat (24) @(posedge clk);
  endtask

  task automatic write_scale(logic [15:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    scale_q = v;
    n_scales++;
    cfg_we <= 1'b0;
  endtask

  // sync if needed, start byte, then random word bytes with a few line errors
  task automatic send_frame();
    if (!in_frame_q) begin
      if (need_sync_q) send_byte(SYNC_BYTE, 1'b0, rand_tele_set());
      send_byte(START_BYTE, 1'b0, rand_tele_set());
    end
    while (in_frame_q)
      send_byte(8'($urandom), ($urandom_range(0, 19) == 0), rand_tele_set());
  endtask

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    link_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation: kind %0d", out_kind);
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        check_field("kind", 16'(e.kind), 16'(out_kind));
        check_field("tx_byte", 16'(e.tx_byte), 16'(out_tx_byte));
        check_field("word_index", 16'(e.word_index), 16'(out_word_index));
        check_field("word_value", e.word_value, out_word_value);
        check_field("frame_done", 16'(e.frame_done), 16'(out_frame_done));
        check_field("last", 16'(e.last), 16'(out_last));
        case (e.kind)
          KIND_REPLY: n_replies++;
          KIND_WORD:  n_cmds++;
          default:    n_errs++;
        endcase
      end
    end
  end

  initial begin : out_side
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!quiet_phase && $urandom_range(0, 99) < 25) begin
        stall_left = idle_len() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // first frame after reset needs only the start byte
  task automatic test_first_frame();
    logic [7:0] cmd_bytes [14] = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h7F,
                                   8'h01, 8'h00, 8'h55, 8'hAA, 8'hAA, 8'h55};
    send_byte(START_BYTE, 1'b0,
              {32'h0001_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    for (int i = 0; i < 14; i++) begin
      if (i == 7) send_byte(8'hA5, 1'b1, rand_tele_set());
      send_byte(cmd_bytes[i], 1'b0, rand_tele_set());
    end
    drain();
  endtask

  task automatic test_sync_rules();
    send_byte(START_BYTE, 1'b1, rand_tele_set());
    send_byte(START_BYTE, 1'b0, rand_tele_set());
    send_byte(SYNC_BYTE, 1'b0, rand_tele_set());
    send_byte(8'h00, 1'b0, rand_tele_set());
    send_byte(START_BYTE, 1'b0, rand_tele_set());
    send_byte(SYNC_BYTE, 1'b0, rand_tele_set());
    send_byte(SYNC_BYTE, 1'b0, rand_tele_set());
    send_byte(SYNC_BYTE, 1'b0, rand_tele_set());
    send_byte(START_BYTE, 1'b0,
              {32'hFFFF_0000, 32'h0000_8000, 32'h7FFF_0000, 32'h8000_0001});
    drain();
  endtask

  task automatic run_traffic(int n_items);
    int stop_at;
    int r;
    int k;
    logic [7:0] b;
    stop_at = active_words + n_items;
    while (active_words < stop_at) begin
      quiet_phase = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_frame();
      end else if (r < 88) begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          case ($urandom_range(0, 3))
            0: b = SYNC_BYTE;
            1: b = START_BYTE;
            default: b = 8'($urandom);
          endcase
          send_byte(b, ($urandom_range(0, 9) == 0), rand_tele_set());
        end
      end else begin
        send_byte(SYNC_BYTE, 1'b0, rand_tele_set());
        send_byte(8'($urandom), ($urandom_range(0, 1) == 0), rand_tele_set());
      end
    end
    quiet_phase = 1'b0;
  endtask

  task automatic test_scale_sweep();
    logic [15:0] scales [5];
    scales = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), SCALE_RESET};
    foreach (scales[i]) begin
      drain();
      write_scale(scales[i]);
      run_traffic(52);
    end
    drain();
  endtask

  // output held off while two back-to-back frames are offered
  task automatic test_backpressure();
    hold_req = 400;
    quiet_phase = 1'b1;
    send_frame();
    send_frame();
    quiet_phase = 1'b0;
    drain();
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_data       <= 16'h0000;
    in_valid       <= 1'b0;
    in_rx_byte     <= 8'h00;
    in_rx_error    <= 1'b0;
    in_telemetry_a <= 32'h0;
    in_telemetry_b <= 32'h0;
    in_telemetry_c <= 32'h0;
    in_telemetry_d <= 32'h0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_frame();
    test_sync_rules();
    test_scale_sweep();
    test_backpressure();
    $display("Sent %0d words, %0d frames opened, %0d scale settings", words_sent, n_frames,
             n_scales);
    $display("Checked %0d reply bytes, %0d command words, %0d line errors", n_replies,
             n_cmds, n_errs);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/fclp_pkg.sv
sv/fclp_queue.sv
sv/fclp_front.sv
sv/fclp_back.sv
sv/framed_command_link_parser_core.sv
sv/fclp_checker.sv
dv/tb_framed_command_link_parser_core.sv
